// ===== rtl/core/kls_pkg.sv =====
// ----------------------------------------------------------------------------
// kls_pkg
// Shared sizes, types and helpers for the k-th largest stream tracker.
// ----------------------------------------------------------------------------
package kls_pkg;

  // heap capacity and derived widths
  localparam int MAX_K = 64;
  localparam int IDX_W = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int CNT_W = $clog2(MAX_K + 1);
  localparam int CH_W  = IDX_W + 2;
  localparam int K_W   = 7;
  localparam int KX_W  = (K_W > CNT_W) ? K_W : CNT_W;
  localparam int VAL_W = 32;

  typedef logic signed [VAL_W-1:0] val_t;

  // rank as used: zero acts as one, large ranks saturate at capacity
  function automatic logic [CNT_W-1:0] eff_k(input logic [K_W-1:0] k);
    logic [KX_W-1:0] kx;
    kx = KX_W'(k);
    if (kx == '0) begin
      return CNT_W'(1);
    end
    if (kx > KX_W'(MAX_K)) begin
      return CNT_W'(MAX_K);
    end
    return CNT_W'(kx);
  endfunction

endpackage

// ===== rtl/core/kls_ram.sv =====
// ----------------------------------------------------------------------------
// kls_ram
// Generic simple dual-port RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module kls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/core/kth_largest_stream_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// kth_largest_stream_tracker_unit
// Tracks the k-th largest signed value of a stream with a min-heap in RAM.
// ----------------------------------------------------------------------------
// One item is worked at a time; a new item is taken as soon as the previous
// one has moved to the output register, even while that result still waits.
// A value that is dropped, the first append into an empty heap and a root
// replacement with k = 1 need no heap walk. An append climbs with sift-up,
// and a root replacement descends with sift-down, which reads the left child
// and, where it exists, the right child of each level that it examines. The
// heap RAM has a single read port, so each level costs one read per child.
// Writing k_rank clears the fill count; the heap RAM needs no clearing.
module kth_largest_stream_tracker_unit (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [kls_pkg::K_W-1:0]  cfg_wr_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  kls_pkg::val_t            in_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output kls_pkg::val_t            out_kth_value,
  output logic                     out_heap_full
);

  import kls_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP,
    ST_DN_L,
    ST_DN_R,
    ST_WR,
    ST_OUT
  } state_t;

  state_t            state_r, state_nxt;
  val_t              key_r, key_nxt;
  val_t              lval_r, lval_nxt;
  val_t              root_r, root_nxt;
  logic [IDX_W-1:0]  pos_r, pos_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic [K_W-1:0]    k_rank_r, k_rank_nxt;
  logic              out_valid_r, out_valid_nxt;
  val_t              out_kth_r, out_kth_nxt;
  logic              out_full_r, out_full_nxt;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  val_t              ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [VAL_W-1:0]  ram_rdata;
  val_t              rd_val;

  logic [CNT_W-1:0]  effk;
  logic [CH_W-1:0]   fill_ch;
  logic [CH_W-1:0]   l_idx;
  logic [CH_W-1:0]   r_idx;
  logic [CH_W-1:0]   nl_idx;
  logic [IDX_W-1:0]  par_idx;
  logic              dn_step;
  val_t              dn_cv;
  logic [IDX_W-1:0]  dn_ci;
  logic              accept;

  // heap storage
  kls_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MAX_K)
  ) u_heap_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign rd_val  = $signed(ram_rdata);
  assign effk    = eff_k(k_rank_r);
  assign fill_ch = CH_W'(fill_r);
  assign l_idx   = {1'b0, pos_r, 1'b1};
  assign r_idx   = l_idx + CH_W'(1);
  assign par_idx = IDX_W'((pos_r - IDX_W'(1)) >> 1);
  assign accept  = in_valid && !in_stall;
  assign nl_idx  = {1'b0, dn_ci, 1'b1};

  // smaller child for the sift-down step
  always_comb begin
    dn_cv = rd_val;
    dn_ci = l_idx[IDX_W-1:0];
    if (state_r == ST_DN_R) begin
      if (rd_val < lval_r) begin
        dn_cv = rd_val;
        dn_ci = r_idx[IDX_W-1:0];
      end else begin
        dn_cv = lval_r;
        dn_ci = l_idx[IDX_W-1:0];
      end
    end
  end

  // control and heap access
  always_comb begin
    state_nxt     = state_r;
    key_nxt       = key_r;
    lval_nxt      = lval_r;
    pos_nxt       = pos_r;
    fill_nxt      = fill_r;
    k_rank_nxt    = k_rank_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_kth_nxt   = out_kth_r;
    out_full_nxt  = out_full_r;
    ram_we        = 1'b0;
    ram_waddr     = pos_r;
    ram_wdata     = key_r;
    ram_raddr     = '0;
    dn_step       = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          key_nxt = in_value;
          if (fill_r < effk) begin
            // append at the end, then climb
            fill_nxt = fill_r + CNT_W'(1);
            pos_nxt  = IDX_W'(fill_r);
            if (fill_r == '0) begin
              ram_we    = 1'b1;
              ram_waddr = '0;
              ram_wdata = in_value;
              state_nxt = ST_OUT;
            end else begin
              ram_raddr = IDX_W'((fill_r - CNT_W'(1)) >> 1);
              state_nxt = ST_UP;
            end
          end else if (in_value > root_r) begin
            // replace the root, then descend
            pos_nxt = '0;
            if (fill_ch > CH_W'(1)) begin
              ram_raddr = IDX_W'(1);
              state_nxt = ST_DN_L;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = '0;
              ram_wdata = in_value;
              state_nxt = ST_OUT;
            end
          end else begin
            state_nxt = ST_OUT;
          end
        end
      end

      ST_UP: begin
        if (rd_val > key_r) begin
          ram_we    = 1'b1;
          ram_waddr = pos_r;
          ram_wdata = rd_val;
          pos_nxt   = par_idx;
          if (par_idx != '0) begin
            ram_raddr = IDX_W'((par_idx - IDX_W'(1)) >> 1);
          end else begin
            state_nxt = ST_WR;
          end
        end else begin
          ram_we    = 1'b1;
          ram_waddr = pos_r;
          ram_wdata = key_r;
          state_nxt = ST_OUT;
        end
      end

      ST_DN_L: begin
        if (r_idx < fill_ch) begin
          lval_nxt  = rd_val;
          ram_raddr = r_idx[IDX_W-1:0];
          state_nxt = ST_DN_R;
        end else begin
          dn_step = 1'b1;
        end
      end

      ST_DN_R: begin
        dn_step = 1'b1;
      end

      ST_WR: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r;
        ram_wdata = key_r;
        state_nxt = ST_OUT;
      end

      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_kth_nxt   = root_r;
          out_full_nxt  = (fill_r == effk);
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // one sift-down level: move the smaller child up if it beats the key
    if (dn_step) begin
      if (dn_cv < key_r) begin
        ram_we    = 1'b1;
        ram_waddr = pos_r;
        ram_wdata = dn_cv;
        pos_nxt   = dn_ci;
        if (nl_idx < fill_ch) begin
          ram_raddr = nl_idx[IDX_W-1:0];
          state_nxt = ST_DN_L;
        end else begin
          state_nxt = ST_WR;
        end
      end else begin
        ram_we    = 1'b1;
        ram_waddr = pos_r;
        ram_wdata = key_r;
        state_nxt = ST_OUT;
      end
    end

    // register write clears the fill count
    if (cfg_wr_en) begin
      k_rank_nxt = cfg_wr_data;
      fill_nxt   = '0;
    end
  end

  // shadow copy of entry zero
  always_comb begin
    root_nxt = root_r;
    if (ram_we && ram_waddr == '0) begin
      root_nxt = ram_wdata;
    end
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      k_rank_r    <= K_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      k_rank_r    <= k_rank_nxt;
      out_valid_r <= out_valid_nxt;
    end
    key_r     <= key_nxt;
    lval_r    <= lval_nxt;
    pos_r     <= pos_nxt;
    root_r    <= root_nxt;
    out_kth_r <= out_kth_nxt;
    out_full_r <= out_full_nxt;
  end

  assign in_stall      = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_kth_value = out_kth_r;
  assign out_heap_full = out_full_r;

endmodule

// ===== rtl/core/kls_checker.sv =====
// ----------------------------------------------------------------------------
// kls_checker
// Port-level checks for the k-th largest stream tracker, bound to the top.
// ----------------------------------------------------------------------------
module kls_checker (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    cfg_wr_en,
  input logic [6:0]              cfg_wr_data,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic signed [31:0]      in_value,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic signed [31:0]      out_kth_value,
  input logic                    out_heap_full
);

  // a waiting result is not withdrawn
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result item withdrawn while stalled");

  // a waiting result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_kth_value) && $stable(out_heap_full))
    else $error("result item changed while stalled");

  // an accepted item keeps the block busy in the following cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted back to back");

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result item present after reset");

endmodule

bind kth_largest_stream_tracker_unit kls_checker u_kls_checker (.*);

// ===== tb/sv/kth_largest_stream_tracker_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kth_largest_stream_tracker_unit_test
// Self-checking bench for the k-th largest stream tracker. A table of directed
// items and rank writes runs first, then random phases, each with its own rank.
// A min-heap predictor works out the root and full flag for every accepted
// item, and a monitor checks each accepted result against the oldest one.
// ----------------------------------------------------------------------------
module kth_largest_stream_tracker_unit_test;
  import kls_pkg::*;

  localparam int          RANDOM_ITEMS = 1100;
  localparam int          SETTLE_CYCLES = 24;
  localparam int          CYCLE_LIMIT = 600000;
  localparam int          DIR_ROWS = 31;
  localparam logic [31:0] SIGN_FLIP = 32'h8000_0000;
  localparam val_t        V_MIN = 32'sh8000_0000;
  localparam val_t        V_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    val_t kth;
    logic full;
  } tracker_result_t;

  // one directed row: either a rank write or an item, optionally with a typed result
  typedef struct {
    bit               set_rank;
    logic [K_W-1:0]   rank;
    val_t             value;
    bit               typed;
    val_t             want_kth;
    bit               want_full;
  } stim_row_t;

  logic           clk;
  logic           rst_n;
  logic           cfg_wr_en;
  logic [K_W-1:0] cfg_wr_data;
  logic           in_valid;
  logic           in_stall;
  val_t           in_value;
  logic           out_valid;
  logic           out_stall = 1'b0;
  val_t           out_kth_value;
  logic           out_heap_full;

  // predictor state: keys stored with the sign bit flipped
  logic [31:0]    heap_keys [MAX_K];
  int unsigned    heap_count;
  logic [K_W-1:0] rank_reg;

  tracker_result_t kth_expect_q[$];
  int unsigned     error_count = 0;
  int unsigned     cycle_count = 0;
  int unsigned     stall_left = 0;
  int unsigned     calm_left = 0;
  val_t            run_value;
  stim_row_t       dir_rows [DIR_ROWS];

  kth_largest_stream_tracker_unit uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_kth_value(out_kth_value),
    .out_heap_full(out_heap_full)
  );

  // clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // min-heap update for one value, returns the new root and full flag
  function automatic tracker_result_t track_value(input val_t v);
    logic [31:0]     key;
    logic [31:0]     tmp;
    int unsigned     cap;
    int unsigned     pos;
    int unsigned     up;
    int unsigned     lc;
    int unsigned     rc;
    int unsigned     pick;
    tracker_result_t res;
    key = v ^ SIGN_FLIP;
    cap = (rank_reg == '0) ? 1 : ((rank_reg > MAX_K) ? MAX_K : rank_reg);
    if (heap_count > cap) heap_count = cap;
    if (heap_count < cap) begin
      // append and climb
      heap_keys[heap_count] = key;
      pos = heap_count;
      heap_count++;
      while (pos > 0) begin
        up = (pos - 1) / 2;
        if (heap_keys[up] > heap_keys[pos]) begin
          tmp = heap_keys[up];
          heap_keys[up] = heap_keys[pos];
          heap_keys[pos] = tmp;
          pos = up;
        end else begin
          break;
        end
      end
    end else if (key > heap_keys[0]) begin
      // replace root and descend
      heap_keys[0] = key;
      pos = 0;
      while (1) begin
        lc = 2 * pos + 1;
        rc = 2 * pos + 2;
        pick = pos;
        if (lc < heap_count && heap_keys[lc] < heap_keys[pick]) pick = lc;
        if (rc < heap_count && heap_keys[rc] < heap_keys[pick]) pick = rc;
        if (pick == pos) break;
        tmp = heap_keys[pos];
        heap_keys[pos] = heap_keys[pick];
        heap_keys[pick] = tmp;
        pos = pick;
      end
    end
    res.kth = val_t'(heap_keys[0] ^ SIGN_FLIP);
    res.full = (heap_count == cap);
    return res;
  endfunction

  // random value: wide, clustered, extremes, near the root, or climbing
  function automatic val_t pick_value();
    int unsigned r;
    val_t        v;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      v = $urandom;
    end else if (r < 62) begin
      v = $urandom_range(0, 32);
      v = v - 16;
    end else if (r < 72) begin
      case ($urandom_range(0, 5))
        0: v = V_MIN;
        1: v = V_MAX;
        2: v = 0;
        3: v = -1;
        4: v = V_MIN + 1;
        default: v = V_MAX - 1;
      endcase
    end else if (r < 88 && heap_count != 0) begin
      v = $urandom_range(0, 6);
      v = val_t'(heap_keys[0] ^ SIGN_FLIP) + v - 3;
    end else begin
      run_value = run_value + val_t'($urandom_range(1, 5000));
      v = run_value;
    end
    return v;
  endfunction

  // sender gap: mostly none or short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // present one item, hold it until taken, then log its expected result
  task automatic push_value(input val_t v, input bit typed, input tracker_result_t typed_res);
    tracker_result_t res;
    in_valid <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (in_stall);
    res = track_value(v);
    kth_expect_q.push_back(typed ? typed_res : res);
  endtask

  // drop valid, optionally idle
  task automatic sender_gap(input int unsigned gap);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending and wait until every result is back
  task automatic settle_block();
    in_valid <= 1'b0;
    while (kth_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // rank write while idle, clears the fill count
  task automatic set_rank(input logic [K_W-1:0] k);
    settle_block();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= k;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    rank_reg = k;
    heap_count = 0;
  endtask

  // receiver stall pattern
  always @(posedge clk) begin
    int unsigned pick;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (calm_left != 0) begin
      calm_left--;
      out_stall <= 1'b0;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        out_stall <= 1'b0;
      end else if (pick < 88) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(0, 2);
      end else if (pick < 96) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(8, 40);
      end else begin
        out_stall <= 1'b0;
        calm_left = $urandom_range(50, 300);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    tracker_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (kth_expect_q.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected result: kth_value=%0d heap_full=%0b",
                   out_kth_value, out_heap_full);
      end else begin
        want = kth_expect_q.pop_front();
        if (out_kth_value !== want.kth || out_heap_full !== want.full) begin
          error_count++;
          if (error_count <= 10)
            $display("mismatch: kth_value exp %0d got %0d, heap_full exp %0b got %0b",
                     want.kth, out_kth_value, want.full, out_heap_full);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("kth_largest_stream_tracker_unit_test: done, errors");
      $finish;
    end
  end

  initial begin
    tracker_result_t typed_res;
    int unsigned     sent;
    int unsigned     phase_items;
    int unsigned     cap;
    int unsigned     r;
    bit              no_gaps;
    logic [K_W-1:0]  k;

    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_value = '0;
    run_value = V_MIN;
    heap_count = 0;
    rank_reg = 7'd1;

    // directed rows
    dir_rows = '{
      // rank 1 after reset: root follows the largest so far
      '{1'b0, 7'd0,   V_MIN, 1'b1, V_MIN, 1'b1},
      '{1'b0, 7'd0,   V_MAX, 1'b1, V_MAX, 1'b1},
      '{1'b0, 7'd0,   V_MAX, 1'b1, V_MAX, 1'b1},
      '{1'b0, 7'd0,   0,     1'b1, V_MAX, 1'b1},
      // rank zero acts as rank one
      '{1'b1, 7'd0,   0,     1'b0, 0,     1'b0},
      '{1'b0, 7'd0,   5,     1'b1, 5,     1'b1},
      '{1'b0, 7'd0,   -1,    1'b1, 5,     1'b1},
      '{1'b0, 7'd0,   6,     1'b1, 6,     1'b1},
      // rank 3: fill, equal to root dropped, then replacements
      '{1'b1, 7'd3,   0,     1'b0, 0,     1'b0},
      '{1'b0, 7'd0,   10,    1'b1, 10,    1'b0},
      '{1'b0, 7'd0,   20,    1'b1, 10,    1'b0},
      '{1'b0, 7'd0,   5,     1'b1, 5,     1'b1},
      '{1'b0, 7'd0,   5,     1'b1, 5,     1'b1},
      '{1'b0, 7'd0,   15,    1'b0, 0,     1'b0},
      '{1'b0, 7'd0,   -100,  1'b0, 0,     1'b0},
      '{1'b0, 7'd0,   V_MAX, 1'b0, 0,     1'b0},
      // rank above capacity saturates
      '{1'b1, 7'd127, 0,     1'b0, 0,     1'b0},
      '{1'b0, 7'd0,   V_MAX, 1'b1, V_MAX, 1'b0},
      '{1'b0, 7'd0,   V_MIN, 1'b1, V_MIN, 1'b0},
      '{1'b0, 7'd0,   -7,    1'b0, 0,     1'b0},
      '{1'b1, 7'd65,  0,     1'b0, 0,     1'b0},
      '{1'b0, 7'd0,   7,     1'b1, 7,     1'b0},
      '{1'b0, 7'd0,   3,     1'b0, 0,     1'b0},
      // full capacity
      '{1'b1, 7'd64,  0,     1'b0, 0,     1'b0},
      '{1'b0, 7'd0,   100,   1'b0, 0,     1'b0},
      '{1'b0, 7'd0,   -3,    1'b0, 0,     1'b0},
      '{1'b0, 7'd0,   50,    1'b0, 0,     1'b0},
      '{1'b0, 7'd0,   50,    1'b0, 0,     1'b0},
      // back to rank 1
      '{1'b1, 7'd1,   0,     1'b0, 0,     1'b0},
      '{1'b0, 7'd0,   -9,    1'b1, -9,    1'b1},
      '{1'b0, 7'd0,   -10,   1'b1, -9,    1'b1}
    };

    // reset
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].set_rank) begin
        set_rank(dir_rows[i].rank);
      end else begin
        typed_res.kth = dir_rows[i].want_kth;
        typed_res.full = dir_rows[i].want_full;
        push_value(dir_rows[i].value, dir_rows[i].typed, typed_res);
        sender_gap(pick_gap());
      end
    end

    // random phases, each with its own rank
    sent = 0;
    typed_res = '0;
    while (sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 45) k = K_W'($urandom_range(1, 8));
      else if (r < 70) k = K_W'($urandom_range(9, 40));
      else if (r < 78) k = 7'd64;
      else if (r < 84) k = K_W'($urandom_range(65, 127));
      else if (r < 87) k = 7'd0;
      else if (r < 92) k = K_W'($urandom_range(41, 63));
      else k = rank_reg;
      // keeping the rank: half the time just pause until every result is back, else rewrite it
      if (k == rank_reg && $urandom_range(0, 1) == 0) settle_block();
      else set_rank(k);
      cap = (rank_reg == '0) ? 1 : ((rank_reg > MAX_K) ? MAX_K : rank_reg);
      phase_items = cap + $urandom_range(1, 2 * cap + 10);
      if (phase_items > RANDOM_ITEMS - sent) phase_items = RANDOM_ITEMS - sent;
      no_gaps = ($urandom_range(0, 3) == 0);
      run_value = $urandom;
      repeat (phase_items) begin
        push_value(pick_value(), 1'b0, typed_res);
        sent++;
        if ($urandom_range(0, 199) == 0) settle_block();
        else if (!no_gaps) sender_gap(pick_gap());
      end
    end

    // drain and finish
    in_valid <= 1'b0;
    while (kth_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && kth_expect_q.size() == 0)
      $display("kth_largest_stream_tracker_unit_test: done, clean");
    else
      $display("kth_largest_stream_tracker_unit_test: done, errors");
    $finish;
  end

endmodule
